[rtl/core/rno_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rno_pkg
// Shared types, codes and calendar helpers for the next-occurrence core.
// ----------------------------------------------------------------------------
package rno_pkg;

  localparam int DATE_W   = 23;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int MINUTE_W = 11;
  localparam int AFTER_W  = 12;
  localparam int RULE_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int YY_W     = 15;  // year + 400, with January/February shift
  localparam int Q100_W   = 8;
  localparam int SUM_W    = 15;
  localparam int Q7_W     = 12;
  localparam int MUL_W    = 15;

  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'h3FFF;

  // reciprocal constants: x/100 = (x*5243)>>19, x/7 = (x*18725)>>17 (x < 2^15)
  localparam logic [MUL_W-1:0] DIV100_MUL = 15'd5243;
  localparam logic [MUL_W-1:0] DIV7_MUL   = 15'd18725;

  // rule codes
  localparam logic [RULE_W-1:0] RULE_NONE    = 3'd0;
  localparam logic [RULE_W-1:0] RULE_DAILY   = 3'd1;
  localparam logic [RULE_W-1:0] RULE_WEEKLY  = 3'd2;
  localparam logic [RULE_W-1:0] RULE_MDAY    = 3'd3;
  localparam logic [RULE_W-1:0] RULE_NTH     = 3'd4;
  localparam logic [RULE_W-1:0] RULE_YEARLY  = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RULE_TYPE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEEKDAY_MASK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAY_OF_MONTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NTH_WEEK       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WEEKDAY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_MONTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DATE      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_MINUTE  = 3'd7;

  // command codes
  localparam logic CMD_TEST = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  // datapath operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
  localparam logic [OP_W-1:0] OP_DIVY  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIVYY = 3'd3;
  localparam logic [OP_W-1:0] OP_SUM   = 3'd4;
  localparam logic [OP_W-1:0] OP_DIV7  = 3'd5;
  localparam logic [OP_W-1:0] OP_REM   = 3'd6;
  localparam logic [OP_W-1:0] OP_STEP  = 3'd7;

  typedef struct packed {
    logic                       command;
    logic [DATE_W-1:0]          query_date;
    logic                       has_after;
    logic signed [AFTER_W-1:0]  after_minute;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [DATE_W-1:0]   result_date;
    logic [MINUTE_W-1:0] result_minute;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DATE_W-1:0]    value;
  } cfg_wr_t;

  typedef struct packed {
    logic [RULE_W-1:0]   rule_type;
    logic [6:0]          weekday_mask;
    logic [DAY_W-1:0]    day_of_month;
    logic [2:0]          nth_week;
    logic [2:0]          target_weekday;
    logic [MONTH_W-1:0]  target_month;
    logic [DATE_W-1:0]   base_date;
    logic [MINUTE_W-1:0] anchor_minute;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            sel_start;    // LOAD: query/start date instead of anchor
    logic            save_anchor;  // REM: keep weekday and validity of anchor
    logic            capture;      // latch the input word
    logic            finish;       // write the output register
    logic            found;
  } dp_cmd_t;

  typedef struct packed {
    logic command;
    logic date_ok;
    logic hit;
    logic last;
    logic out_free;
  } dp_stat_t;

  // month offsets of the weekday formula
  function automatic logic [2:0] sak_offset(input logic [MONTH_W-1:0] m);
    logic [2:0] r;
    case (m)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd2:                         r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      r = 5'd30;
      default:                      r = 5'd31;
    endcase
    return r;
  endfunction

  // (d-1)/7 + 1 for d in 1..31
  function automatic logic [2:0] week_of_day(input logic [DAY_W-1:0] d);
    logic [2:0] r;
    if (d <= 5'd7) begin
      r = 3'd1;
    end else if (d <= 5'd14) begin
      r = 3'd2;
    end else if (d <= 5'd21) begin
      r = 3'd3;
    end else if (d <= 5'd28) begin
      r = 3'd4;
    end else begin
      r = 3'd5;
    end
    return r;
  endfunction

endpackage

[rtl/core/rno_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rno_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface rno_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/rno_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rno_cfg
// Rule configuration registers, written through the config channel.
// ----------------------------------------------------------------------------
module rno_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  output logic                 wr_ready_o,
  input  rno_pkg::cfg_wr_t     wr_i,
  output rno_pkg::cfg_t        cfg_o
);
  import rno_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (wr_i.index)
        REG_RULE_TYPE:      cfg_d.rule_type      = wr_i.value[RULE_W-1:0];
        REG_WEEKDAY_MASK:   cfg_d.weekday_mask   = wr_i.value[6:0];
        REG_DAY_OF_MONTH:   cfg_d.day_of_month   = wr_i.value[DAY_W-1:0];
        REG_NTH_WEEK:       cfg_d.nth_week       = wr_i.value[2:0];
        REG_TARGET_WEEKDAY: cfg_d.target_weekday = wr_i.value[2:0];
        REG_TARGET_MONTH:   cfg_d.target_month   = wr_i.value[MONTH_W-1:0];
        REG_BASE_DATE:      cfg_d.base_date      = wr_i.value[DATE_W-1:0];
        REG_ANCHOR_MINUTE:  cfg_d.anchor_minute  = wr_i.value[MINUTE_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rule_type      <= RULE_NONE;
      cfg_q.weekday_mask   <= '0;
      cfg_q.day_of_month   <= 5'd1;
      cfg_q.nth_week       <= 3'd1;
      cfg_q.target_weekday <= '0;
      cfg_q.target_month   <= 4'd1;
      cfg_q.base_date      <= '0;
      cfg_q.anchor_minute  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/rno_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rno_ctrl
// Sequencer: weekday setup for anchor and start date, day walk, result hand-off.
// ----------------------------------------------------------------------------
module rno_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rno_pkg::dp_stat_t    stat_i,
  output rno_pkg::dp_cmd_t     cmd_o
);
  import rno_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] ST_LOAD  = 4'd1;
  localparam logic [ST_W-1:0] ST_DIVY  = 4'd2;
  localparam logic [ST_W-1:0] ST_DIVYY = 4'd3;
  localparam logic [ST_W-1:0] ST_SUM   = 4'd4;
  localparam logic [ST_W-1:0] ST_DIV7  = 4'd5;
  localparam logic [ST_W-1:0] ST_REM   = 4'd6;
  localparam logic [ST_W-1:0] ST_WALK  = 4'd7;
  localparam logic [ST_W-1:0] ST_DONE  = 4'd8;

  logic [ST_W-1:0] state_q, state_d;
  logic            pass_q, pass_d;   // 0: anchor date, 1: start date
  logic            found_q, found_d;

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    found_d    = found_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = OP_NOP;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          pass_d        = 1'b0;
          state_d       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.op        = OP_LOAD;
        cmd_o.sel_start = pass_q;
        state_d         = ST_DIVY;
      end
      ST_DIVY: begin
        cmd_o.op = OP_DIVY;
        state_d  = ST_DIVYY;
      end
      ST_DIVYY: begin
        cmd_o.op = OP_DIVYY;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = ST_DIV7;
      end
      ST_DIV7: begin
        cmd_o.op = OP_DIV7;
        state_d  = ST_REM;
      end
      ST_REM: begin
        cmd_o.op          = OP_REM;
        cmd_o.save_anchor = !pass_q;
        if (!pass_q) begin
          pass_d  = 1'b1;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!stat_i.date_ok) begin
          found_d = 1'b0;
          state_d = ST_DONE;
        end else if (stat_i.hit) begin
          found_d = 1'b1;
          state_d = ST_DONE;
        end else if (stat_i.command == CMD_TEST || stat_i.last) begin
          found_d = 1'b0;
          state_d = ST_DONE;
        end else begin
          cmd_o.op = OP_STEP;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.found  = found_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      found_q <= found_d;
    end
  end

  a_accept_starts_anchor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_LOAD && !pass_q))
    else $error("accepted word did not start the anchor pass");

  a_anchor_then_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REM && !pass_q) |=> (state_q == ST_LOAD && pass_q))
    else $error("start-date pass did not follow the anchor pass");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !stat_i.out_free) |=> (state_q == ST_DONE && $stable(found_q)))
    else $error("result lost while output stalled");

endmodule

[rtl/core/rno_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rno_dp
// Calendar datapath: weekday via shared reciprocal multiplier, day counter
// with year-mod counters, rule match and output register.
// ----------------------------------------------------------------------------
module rno_dp #(
  parameter int HORIZON_DAYS        = 750,
  parameter int YEARLY_HORIZON_DAYS = 1500
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rno_pkg::dp_cmd_t     cmd_i,
  output rno_pkg::dp_stat_t    stat_o,
  input  rno_pkg::cfg_t        cfg_i,
  input  rno_pkg::in_item_t    in_item_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output rno_pkg::out_item_t   out_item_o
);
  import rno_pkg::*;

  localparam int MAX_H = (HORIZON_DAYS > YEARLY_HORIZON_DAYS) ?
                         HORIZON_DAYS : YEARLY_HORIZON_DAYS;
  localparam int CNT_W = $clog2(MAX_H + 1);
  localparam logic [CNT_W-1:0] LAST_STD = CNT_W'(HORIZON_DAYS - 1);
  localparam logic [CNT_W-1:0] LAST_YR  = CNT_W'(YEARLY_HORIZON_DAYS - 1);

  // latched input word
  logic                       command_q;
  logic [DATE_W-1:0]          query_q;
  logic                       has_after_q;
  logic signed [AFTER_W-1:0]  after_min_q;

  // walking date and helpers
  logic [YEAR_W-1:0]  cur_y_q;
  logic [MONTH_W-1:0] cur_m_q;
  logic [DAY_W-1:0]   cur_d_q;
  logic [YY_W-1:0]    yy_q;
  logic [Q100_W-1:0]  q100_q, qyy100_q;
  logic [1:0]         mod4_q;
  logic [6:0]         mod100_q;
  logic [8:0]         mod400_q;
  logic [SUM_W-1:0]   sum_q;
  logic [Q7_W-1:0]    q7_q;
  logic [2:0]         wd_q;
  logic [2:0]         anchor_wd_q;
  logic               anchor_ok_q;
  logic [CNT_W-1:0]   cnt_q;

  // output register
  logic                out_valid_q;
  logic                found_q;
  logic [DATE_W-1:0]   date_q;
  logic [MINUTE_W-1:0] minute_q;

  // shared multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;

  always_comb begin
    case (cmd_i.op)
      OP_DIVY:  begin mul_a = {1'b0, cur_y_q}; mul_b = DIV100_MUL; end
      OP_DIVYY: begin mul_a = yy_q;            mul_b = DIV100_MUL; end
      OP_DIV7:  begin mul_a = sum_q;           mul_b = DIV7_MUL;   end
      default:  begin mul_a = '0;              mul_b = '0;         end
    endcase
  end
  assign prod = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

  // date source for LOAD
  logic [DATE_W-1:0] start_date, src_date;
  logic [YEAR_W-1:0] src_y;
  logic [MONTH_W-1:0] src_m;
  logic [DAY_W-1:0]  src_d;
  assign start_date = (has_after_q && query_q > cfg_i.base_date) ? query_q
                                                                 : cfg_i.base_date;
  assign src_date = !cmd_i.sel_start     ? cfg_i.base_date :
                    (command_q == CMD_TEST) ? query_q : start_date;
  assign src_y = src_date[DATE_W-1:MONTH_W+DAY_W];
  assign src_m = src_date[MONTH_W+DAY_W-1:DAY_W];
  assign src_d = src_date[DAY_W-1:0];

  // calendar state of the current date
  logic               leap;
  logic [DAY_W-1:0]   mdays;
  logic               date_ok;
  logic               month_end, year_end;
  logic [DATE_W-1:0]  cur_date;
  assign leap      = (mod4_q == 2'd0 && mod100_q != 7'd0) || mod400_q == 9'd0;
  assign mdays     = month_days(cur_m_q, leap);
  assign date_ok   = cur_m_q >= 4'd1 && cur_m_q <= 4'd12 && cur_d_q >= 5'd1 &&
                     cur_d_q <= mdays;
  assign month_end = cur_d_q >= mdays;
  assign year_end  = month_end && cur_m_q == 4'd12;
  assign cur_date  = {cur_y_q, cur_m_q, cur_d_q};

  // intermediate arithmetic
  logic [YEAR_W-1:0] mod100_full, mod400_full;
  logic [SUM_W:0]    sum_full;
  logic [SUM_W-1:0]  rem_full;
  assign mod100_full = cur_y_q - YEAR_W'(q100_q) * 14'd100;
  assign mod400_full = cur_y_q - YEAR_W'(q100_q[Q100_W-1:2]) * 14'd400;
  assign sum_full = {1'b0, yy_q} + (SUM_W+1)'(yy_q[YY_W-1:2]) - (SUM_W+1)'(qyy100_q)
                  + (SUM_W+1)'(qyy100_q[Q100_W-1:2]) + (SUM_W+1)'(sak_offset(cur_m_q))
                  + (SUM_W+1)'(cur_d_q);
  assign rem_full = sum_q - SUM_W'(q7_q) * 15'd7;

  // rule match
  logic [6:0] eff_mask;
  logic       match;
  always_comb begin
    if (cfg_i.weekday_mask != 7'd0) begin
      eff_mask = cfg_i.weekday_mask;
    end else if (anchor_ok_q) begin
      eff_mask = 7'd1 << anchor_wd_q;
    end else begin
      eff_mask = 7'd0;
    end
    case (cfg_i.rule_type)
      RULE_DAILY:  match = 1'b1;
      RULE_WEEKLY: match = eff_mask[wd_q];
      RULE_MDAY:   match = cur_d_q == cfg_i.day_of_month;
      RULE_NTH:    match = wd_q == cfg_i.target_weekday &&
                           week_of_day(cur_d_q) == cfg_i.nth_week;
      RULE_YEARLY: match = cur_m_q == cfg_i.target_month &&
                           cur_d_q == cfg_i.day_of_month;
      default:     match = 1'b0;
    endcase
  end

  logic after_ok, hit, last;
  assign after_ok = !has_after_q || cur_date > query_q ||
                    (cur_date == query_q &&
                     $signed({1'b0, cfg_i.anchor_minute}) > after_min_q);
  assign hit  = (command_q == CMD_TEST) ? (query_q >= cfg_i.base_date && match)
                                        : (after_ok && match);
  assign last = (cnt_q == ((cfg_i.rule_type == RULE_YEARLY) ? LAST_YR : LAST_STD)) ||
                (year_end && cur_y_q == YEAR_MAX);

  assign stat_o.command  = command_q;
  assign stat_o.date_ok  = date_ok;
  assign stat_o.hit      = hit;
  assign stat_o.last     = last;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      command_q   <= in_item_i.command;
      query_q     <= in_item_i.query_date;
      has_after_q <= in_item_i.has_after;
      after_min_q <= in_item_i.after_minute;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        cur_y_q <= src_y;
        cur_m_q <= src_m;
        cur_d_q <= src_d;
        yy_q    <= {1'b0, src_y} + 15'd400 - YY_W'(src_m < 4'd3);
        cnt_q   <= '0;
      end
      OP_DIVY: begin
        q100_q <= prod[26:19];
      end
      OP_DIVYY: begin
        qyy100_q <= prod[26:19];
        mod4_q   <= cur_y_q[1:0];
        mod100_q <= mod100_full[6:0];
        mod400_q <= mod400_full[8:0];
      end
      OP_SUM: begin
        sum_q <= sum_full[SUM_W-1:0];
      end
      OP_DIV7: begin
        q7_q <= prod[28:17];
      end
      OP_REM: begin
        wd_q <= rem_full[2:0];
        if (cmd_i.save_anchor) begin
          anchor_wd_q <= rem_full[2:0];
          anchor_ok_q <= date_ok;
        end
      end
      OP_STEP: begin
        cnt_q <= cnt_q + 1'b1;
        wd_q  <= (wd_q == 3'd6) ? 3'd0 : wd_q + 3'd1;
        if (month_end) begin
          cur_d_q <= 5'd1;
          if (cur_m_q == 4'd12) begin
            cur_m_q  <= 4'd1;
            cur_y_q  <= cur_y_q + 1'b1;
            mod4_q   <= mod4_q + 2'd1;
            mod100_q <= (mod100_q == 7'd99)  ? 7'd0 : mod100_q + 7'd1;
            mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
          end else begin
            cur_m_q <= cur_m_q + 4'd1;
          end
        end else begin
          cur_d_q <= cur_d_q + 5'd1;
        end
      end
      default: begin
      end
    endcase
    if (cmd_i.finish) begin
      found_q  <= cmd_i.found;
      date_q   <= cmd_i.found ? cur_date : '0;
      minute_q <= cmd_i.found ? cfg_i.anchor_minute : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign out_item_o.found         = found_q;
  assign out_item_o.result_date   = date_q;
  assign out_item_o.result_minute = minute_q;

  a_finish_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while occupied");

  a_step_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_STEP) |-> !last)
    else $error("walk stepped past horizon or calendar end");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_REM) |=> (wd_q != 3'd7))
    else $error("weekday remainder out of range");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (date_q == '0 && minute_q == '0))
    else $error("not-found result carries nonzero fields");

endmodule

[rtl/core/recurrence_next_occurrence_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recurrence_next_occurrence_core
// Recurrence rule match test and next-occurrence search over the Gregorian
// calendar, one day examined per cycle.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Word                                          Ready
//  ---------  ---  --------------------------------------------  -----------------
//  in_chan    in   command, query_date, has_after, after_minute  high when idle
//  out_chan   out  found, result_date, result_minute             from consumer
//  cfg_chan   in   index (3b), value (23b)                       always high
//
//  An item examines k days from accept to result valid: 1 for a test, up to
//  HORIZON_DAYS (YEARLY_HORIZON_DAYS for yearly rules) for a search; the day
//  walk (one calendar step per cycle) examines them. Before the walk, the setup
//  steps LOAD, DIVY, DIVYY, SUM, DIV7 and REM, run for the anchor and then for
//  the start date, compute both weekdays through one shared 15x15 reciprocal multiplier.
//  Reset clears the rule registers to their defaults and empties the output.
//  A stalled output holds its word; the next input word is still taken while
//  it waits, and its result waits in turn until the output register frees.
//
module recurrence_next_occurrence_core #(
  parameter int HORIZON_DAYS        = 750,
  parameter int YEARLY_HORIZON_DAYS = 1500
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rno_stream_if.sink   in_chan,
  rno_stream_if.source out_chan,
  rno_stream_if.sink   cfg_chan
);
  import rno_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  in_item_t in_item;
  out_item_t out_item;
  cfg_wr_t  cfg_wr;

  assign in_item = in_chan.data;
  assign cfg_wr  = cfg_chan.data;

  // rule registers
  rno_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_chan.valid),
    .wr_ready_o (cfg_chan.ready),
    .wr_i       (cfg_wr),
    .cfg_o      (cfg)
  );

  // sequencer: setup passes, walk, result hand-off
  rno_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_chan.ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // calendar arithmetic, rule match and output register
  rno_dp #(
    .HORIZON_DAYS        (HORIZON_DAYS),
    .YEARLY_HORIZON_DAYS (YEARLY_HORIZON_DAYS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .cfg_i       (cfg),
    .in_item_i   (in_item),
    .out_ready_i (out_chan.ready),
    .out_valid_o (out_chan.valid),
    .out_item_o  (out_item)
  );

  assign out_chan.data = out_item;

endmodule
